// File: design/cws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cws_pkg;

    localparam int COORD_BITS   = 32;
    localparam int COUNT_BITS   = 16;
    localparam int RADIUS_BITS  = COORD_BITS - 1;
    localparam int PHASE_BITS   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int VEC_BITS     = 34;
    localparam int ANG_BITS     = 33;
    localparam int ACC_BITS     = 64;
    localparam int CFG_IDX_BITS = 3;
    localparam int STEP_BITS    = 5;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNT    = 3'd4;

    localparam logic signed [COORD_BITS-1:0] CENTER_X_RST = 32'sd26214;
    localparam logic signed [COORD_BITS-1:0] CENTER_Y_RST = 32'sd0;
    localparam logic signed [COORD_BITS-1:0] CENTER_Z_RST = 32'sd32768;
    localparam logic [RADIUS_BITS-1:0]       RADIUS_RST   = 31'd9830;
    localparam logic [COUNT_BITS-1:0]        COUNT_RST    = 16'd36;

    localparam logic signed [VEC_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        KIND_SPEED = 2'd0,
        KIND_POSE  = 2'd1,
        KIND_HOME  = 2'd2
    } cmd_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_GO_CENTER   = 3'd1,
        PH_WAIT_CENTER = 3'd2,
        PH_DRAW        = 3'd3,
        PH_WAIT_STEP   = 3'd4,
        PH_DONE        = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        SQ_READY = 3'd0,
        SQ_DIV   = 3'd1,
        SQ_ROT   = 3'd2,
        SQ_MAP   = 3'd3,
        SQ_MUL   = 3'd4
    } seq_t;

    // atan(2^-k) in 2^-32 turn units
    function automatic logic [29:0] atan_turn(input logic [STEP_BITS-1:0] k);
        logic [29:0] a;
        case (k)
            5'd0:    a = 30'd536870912;
            5'd1:    a = 30'd316933406;
            5'd2:    a = 30'd167458907;
            5'd3:    a = 30'd85004756;
            5'd4:    a = 30'd42667331;
            5'd5:    a = 30'd21354465;
            5'd6:    a = 30'd10679838;
            5'd7:    a = 30'd5340245;
            5'd8:    a = 30'd2670163;
            5'd9:    a = 30'd1335087;
            5'd10:   a = 30'd667544;
            5'd11:   a = 30'd333772;
            5'd12:   a = 30'd166886;
            5'd13:   a = 30'd83443;
            5'd14:   a = 30'd41722;
            5'd15:   a = 30'd20861;
            5'd16:   a = 30'd10430;
            5'd17:   a = 30'd5215;
            5'd18:   a = 30'd2608;
            5'd19:   a = 30'd1304;
            5'd20:   a = 30'd652;
            5'd21:   a = 30'd326;
            5'd22:   a = 30'd163;
            5'd23:   a = 30'd81;
            5'd24:   a = 30'd41;
            5'd25:   a = 30'd20;
            5'd26:   a = 30'd10;
            5'd27:   a = 30'd5;
            5'd28:   a = 30'd3;
            5'd29:   a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: design/circle_waypoint_sequencer_top.sv
// Channel   Signals                                   Dir   Word
// item      item_valid, item_stall, start_req,        in    one tick
//           ee_reached
// cmd       cmd_valid, cmd_stall, cmd_kind,           out   one command
//           target_x, pose_y/z, waypoint_index, finished
// cfg       cfg_we, cfg_index, cfg_data               in    register write
//
// A tick that draws a waypoint keeps item_stall high before its word is offered,
// through 32 steps of the radix-2 phase divider, 30 steps of the CORDIC rotation
// loop, a single quadrant map step and 6 steps on the shared multiplier and adder.
// A tick that issues a word then waits until the word is taken.
// item_stall is high while a tick is at work or a command word waits.
// rst_n clears phase, counter and handshake state and reloads the registers.
`timescale 1ns / 1ps
`default_nettype none

module circle_waypoint_sequencer_top
    import cws_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output      logic                           item_stall,
    input  wire logic                           start_req,
    input  wire logic                           ee_reached,
    output      logic                           cmd_valid,
    input  wire logic                           cmd_stall,
    output      logic [1:0]                     cmd_kind,
    output      logic signed [COORD_BITS-1:0]   target_x,
    output      logic signed [COORD_BITS-1:0]   pose_y,
    output      logic signed [COORD_BITS-1:0]   pose_z,
    output      logic [COUNT_BITS-1:0]          waypoint_index,
    output      logic                           finished,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  wire logic [COORD_BITS-1:0]          cfg_data
);

    localparam logic signed [ACC_BITS-1:0]     ROUND_HALF = 64'sd536870912;
    localparam logic signed [COORD_BITS-1:0]   COORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_BITS-1:0]   COORD_MIN  = 32'sh8000_0000;
    localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(PHASE_BITS - 1);
    localparam logic [STEP_BITS-1:0] ROT_LAST = STEP_BITS'(CORDIC_STEPS - 1);
    localparam logic [STEP_BITS-1:0] MUL_LO_Y  = 5'd0;
    localparam logic [STEP_BITS-1:0] MUL_HI_Y  = 5'd1;
    localparam logic [STEP_BITS-1:0] MUL_SUM_Y = 5'd2;
    localparam logic [STEP_BITS-1:0] MUL_LO_Z  = 5'd3;
    localparam logic [STEP_BITS-1:0] MUL_HI_Z  = 5'd4;
    localparam logic [STEP_BITS-1:0] MUL_SUM_Z = 5'd5;

    // configuration
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic [RADIUS_BITS-1:0]       rad_reg;
    logic [COUNT_BITS-1:0]        pc_reg;

    // control
    phase_t                 phase_reg, phase_next;
    seq_t                   seq_reg, seq_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath
    logic [COUNT_BITS-1:0]          rem_reg, rem_next;
    logic [PHASE_BITS-1:0]          quo_reg, quo_next;
    logic signed [VEC_BITS-1:0]     x_reg, x_next, y_reg, y_next;
    logic signed [ANG_BITS-1:0]     z_reg, z_next;
    logic [1:0]                     quad_reg, quad_next;
    logic signed [VEC_BITS-1:0]     co_reg, co_next, si_reg, si_next;
    logic signed [ACC_BITS-1:0]     acc_reg, acc_next;

    // command word
    cmd_kind_t                      kind_reg, kind_next;
    logic signed [COORD_BITS-1:0]   tx_reg, tx_next, ty_reg, ty_next, tz_reg, tz_next;
    logic [COUNT_BITS-1:0]          idx_reg, idx_next;
    logic                           fin_reg, fin_next;

    logic                           item_take;
    logic                           cmd_take;
    logic [COUNT_BITS:0]            rem_dbl;
    logic [COUNT_BITS:0]            rem_diff;
    logic                           rem_ge;
    logic signed [VEC_BITS-1:0]     dx, dy;
    logic signed [ANG_BITS-1:0]     atan_ext;
    logic signed [16:0]             mul_a;
    logic signed [VEC_BITS-1:0]     mul_b;
    logic signed [16+VEC_BITS:0]    prod;
    logic signed [ACC_BITS-1:0]     prod_ext;
    logic signed [VEC_BITS-1:0]     offset;
    logic signed [COORD_BITS-1:0]   sum_base;
    logic signed [COORD_BITS+2:0]   sum_wide;
    logic signed [COORD_BITS-1:0]   sum_sat;
    logic                           mul_hi, mul_use_si;

    assign item_take = item_valid && !item_stall;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign item_stall     = (seq_reg != SQ_READY) || out_valid_reg;
    assign cmd_valid      = out_valid_reg;
    assign cmd_kind       = kind_reg;
    assign target_x       = tx_reg;
    assign pose_y         = ty_reg;
    assign pose_z         = tz_reg;
    assign waypoint_index = idx_reg;
    assign finished       = fin_reg;

    // restoring divide step
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_ge   = rem_dbl >= {1'b0, pc_reg};
    assign rem_diff = rem_dbl - {1'b0, pc_reg};

    // CORDIC micro-rotation
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_ext = {3'b000, atan_turn(step_reg)};

    // radius times trig in two slices, a low 16-bit and a high 15-bit one
    assign mul_hi     = (step_reg == MUL_HI_Y) || (step_reg == MUL_HI_Z);
    assign mul_use_si = (step_reg == MUL_LO_Z) || (step_reg == MUL_HI_Z)
                        || (step_reg == MUL_SUM_Z);
    assign mul_a = mul_hi ? $signed({2'b00, rad_reg[RADIUS_BITS-1:16]})
                          : $signed({1'b0, rad_reg[15:0]});
    assign mul_b = mul_use_si ? si_reg : co_reg;
    assign prod  = mul_a * mul_b;
    assign prod_ext = ACC_BITS'(prod);

    assign offset   = acc_reg[ACC_BITS-1:30];
    assign sum_base = mul_use_si ? cz_reg : cy_reg;
    assign sum_wide = (COORD_BITS+3)'(sum_base) + (COORD_BITS+3)'(offset);

    always_comb
    begin
        if (sum_wide[COORD_BITS+2:COORD_BITS-1] == '0
            || sum_wide[COORD_BITS+2:COORD_BITS-1] == '1)
        begin
            sum_sat = sum_wide[COORD_BITS-1:0];
        end
        else if (sum_wide[COORD_BITS+2])
        begin
            sum_sat = COORD_MIN;
        end
        else
        begin
            sum_sat = COORD_MAX;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        seq_next       = seq_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        quad_next      = quad_reg;
        co_next        = co_reg;
        si_next        = si_reg;
        acc_next       = acc_reg;
        kind_next      = kind_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        tz_next        = tz_reg;
        idx_next       = idx_reg;
        fin_next       = fin_reg;

        if (cmd_take)
        begin
            out_valid_next = 1'b0;
        end

        case (seq_reg)
            SQ_READY:
            begin
                if (item_take)
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (start_req)
                            begin
                                count_next     = '0;
                                phase_next     = PH_GO_CENTER;
                                out_valid_next = 1'b1;
                                kind_next      = KIND_SPEED;
                                tx_next        = '0;
                                ty_next        = '0;
                                tz_next        = '0;
                                idx_next       = '0;
                                fin_next       = 1'b0;
                            end
                        end
                        PH_GO_CENTER:
                        begin
                            phase_next     = PH_WAIT_CENTER;
                            out_valid_next = 1'b1;
                            kind_next      = KIND_POSE;
                            tx_next        = cx_reg;
                            ty_next        = cy_reg;
                            tz_next        = cz_reg;
                            idx_next       = '0;
                            fin_next       = 1'b0;
                        end
                        PH_WAIT_CENTER:
                        begin
                            if (ee_reached)
                            begin
                                phase_next = PH_DRAW;
                            end
                        end
                        PH_DRAW:
                        begin
                            if (count_reg >= pc_reg)
                            begin
                                phase_next     = PH_DONE;
                                out_valid_next = 1'b1;
                                kind_next      = KIND_HOME;
                                tx_next        = '0;
                                ty_next        = '0;
                                tz_next        = '0;
                                idx_next       = '0;
                                fin_next       = 1'b1;
                            end
                            else
                            begin
                                rem_next  = count_reg;
                                quo_next  = '0;
                                step_next = '0;
                                seq_next  = SQ_DIV;
                            end
                        end
                        PH_WAIT_STEP:
                        begin
                            if (ee_reached)
                            begin
                                phase_next = PH_DRAW;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            SQ_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_diff[COUNT_BITS-1:0];
                end
                else
                begin
                    rem_next = rem_dbl[COUNT_BITS-1:0];
                end
                quo_next  = {quo_reg[PHASE_BITS-2:0], rem_ge};
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == DIV_LAST)
                begin
                    step_next = '0;
                    seq_next  = SQ_ROT;
                    x_next    = CORDIC_GAIN;
                    y_next    = '0;
                    z_next    = $signed({3'b000, quo_next[29:0]});
                    quad_next = quo_next[PHASE_BITS-1:PHASE_BITS-2];
                end
            end
            SQ_ROT:
            begin
                if (!z_reg[ANG_BITS-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_ext;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_ext;
                end
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == ROT_LAST)
                begin
                    step_next = '0;
                    seq_next  = SQ_MAP;
                end
            end
            SQ_MAP:
            begin
                case (quad_reg)
                    2'd0:
                    begin
                        co_next = x_reg;
                        si_next = y_reg;
                    end
                    2'd1:
                    begin
                        co_next = -y_reg;
                        si_next = x_reg;
                    end
                    2'd2:
                    begin
                        co_next = -x_reg;
                        si_next = -y_reg;
                    end
                    default:
                    begin
                        co_next = y_reg;
                        si_next = -x_reg;
                    end
                endcase
                seq_next = SQ_MUL;
            end
            SQ_MUL:
            begin
                step_next = step_reg + STEP_BITS'(1);
                case (step_reg)
                    MUL_LO_Y, MUL_LO_Z:
                    begin
                        acc_next = prod_ext + ROUND_HALF;
                    end
                    MUL_HI_Y, MUL_HI_Z:
                    begin
                        acc_next = acc_reg + (prod_ext <<< 16);
                    end
                    MUL_SUM_Y:
                    begin
                        ty_next = sum_sat;
                    end
                    MUL_SUM_Z:
                    begin
                        tz_next        = sum_sat;
                        tx_next        = cx_reg;
                        kind_next      = KIND_POSE;
                        idx_next       = count_reg + COUNT_BITS'(1);
                        fin_next       = 1'b0;
                        count_next     = count_reg + COUNT_BITS'(1);
                        phase_next     = PH_WAIT_STEP;
                        out_valid_next = 1'b1;
                        step_next      = '0;
                        seq_next       = SQ_READY;
                    end
                    default:
                    begin
                        step_next = '0;
                        seq_next  = SQ_READY;
                    end
                endcase
            end
            default:
            begin
                seq_next = SQ_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            seq_reg       <= SQ_READY;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= CENTER_X_RST;
            cy_reg  <= CENTER_Y_RST;
            cz_reg  <= CENTER_Z_RST;
            rad_reg <= RADIUS_RST;
            pc_reg  <= COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: cx_reg  <= $signed(cfg_data);
                REG_CENTER_Y: cy_reg  <= $signed(cfg_data);
                REG_CENTER_Z: cz_reg  <= $signed(cfg_data);
                REG_RADIUS:   rad_reg <= cfg_data[RADIUS_BITS-1:0];
                REG_COUNT:    pc_reg  <= cfg_data[COUNT_BITS-1:0];
                default:
                begin
                    cx_reg <= cx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
        co_reg   <= co_next;
        si_reg   <= si_next;
        acc_reg  <= acc_next;
        kind_reg <= kind_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        tz_reg   <= tz_next;
        idx_reg  <= idx_next;
        fin_reg  <= fin_next;
    end

endmodule

`default_nettype wire

// File: design/cws_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cws_checker
    import cws_pkg::*;
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           item_stall,
    input wire logic                           cmd_valid,
    input wire logic                           cmd_stall,
    input wire logic [1:0]                     cmd_kind,
    input wire logic signed [COORD_BITS-1:0]   target_x,
    input wire logic signed [COORD_BITS-1:0]   pose_y,
    input wire logic signed [COORD_BITS-1:0]   pose_z,
    input wire logic [COUNT_BITS-1:0]          waypoint_index,
    input wire logic                           finished
);

    // stalled word holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_kind)
            && $stable(target_x) && $stable(pose_y) && $stable(pose_z)
            && $stable(waypoint_index) && $stable(finished))
        else $error("command word changed while stalled");

    // single word buffer: a pending word blocks new ticks
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> item_stall)
        else $error("tick taken while a command word waits");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> !cmd_valid)
        else $error("command word repeated after delivery");

    a_home_fields: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd_kind == KIND_HOME) |-> finished
            && (waypoint_index == '0) && (target_x == '0)
            && (pose_y == '0) && (pose_z == '0))
        else $error("home command fields wrong");

    a_speed_fields: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd_kind == KIND_SPEED) |-> !finished
            && (waypoint_index == '0) && (target_x == '0)
            && (pose_y == '0) && (pose_z == '0))
        else $error("speed command fields wrong");

endmodule

bind circle_waypoint_sequencer_top cws_checker u_cws_checker (.*);

`default_nettype wire

// File: tb/sv/circle_waypoint_sequencer_top_tb.sv
`timescale 1ns / 1ps

module circle_waypoint_sequencer_top_tb;
    import cws_pkg::*;

    localparam int     SETTLE_CYCLES = 90;
    localparam int     QUIET_LIMIT   = 4000;
    localparam int     HOLD_CYCLES   = 400;
    localparam longint COORD_TOP     = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_BOTTOM  = -COORD_TOP - 1;
    localparam longint ROUND_Q30     = longint'(1) <<< 29;

    typedef struct packed {
        cmd_kind_t                     kind;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic signed [COORD_BITS-1:0]  z;
        logic [COUNT_BITS-1:0]         idx;
        logic                          fin;
    } cmd_word_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } stall_mode_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_stall;
    logic                         start_req = 1'b0;
    logic                         ee_reached = 1'b0;
    logic                         cmd_valid;
    logic                         cmd_stall = 1'b0;
    logic [1:0]                   cmd_kind;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] pose_y;
    logic signed [COORD_BITS-1:0] pose_z;
    logic [COUNT_BITS-1:0]        waypoint_index;
    logic                         finished;
    logic                         cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
    logic [COORD_BITS-1:0]        cfg_data = '0;

    // shadow of the block: registers and sequence state
    logic signed [COORD_BITS-1:0] ctr_x = CENTER_X_RST;
    logic signed [COORD_BITS-1:0] ctr_y = CENTER_Y_RST;
    logic signed [COORD_BITS-1:0] ctr_z = CENTER_Z_RST;
    logic [RADIUS_BITS-1:0]       radius_now = RADIUS_RST;
    logic [COUNT_BITS-1:0]        count_now = COUNT_RST;
    phase_t                       seq_phase = PH_IDLE;
    logic [COUNT_BITS-1:0]        drawn = '0;

    longint arc_turn [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    cmd_word_t pending_cmds[$];

    int mismatches = 0;
    int ticks_taken = 0;
    int live_ticks = 0;
    int cmds_seen = 0;
    int waypoints_seen = 0;
    int homes_seen = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;
    int hold_off_left = 0;
    int stall_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    circle_waypoint_sequencer_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .start_req      (start_req),
        .ee_reached     (ee_reached),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd_kind       (cmd_kind),
        .target_x       (target_x),
        .pose_y         (pose_y),
        .pose_z         (pose_z),
        .waypoint_index (waypoint_index),
        .finished       (finished),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
        logic signed [COORD_BITS-1:0] r;
        if (v > COORD_TOP)
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        else if (v < COORD_BOTTOM)
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            r = v[COORD_BITS-1:0];
        return r;
    endfunction

    // r*cos and r*sin of waypoint i of n, rounded to Q16.16
    function automatic void circle_offsets(input logic [COUNT_BITS-1:0] i,
                                           input logic [COUNT_BITS-1:0] n,
                                           output longint dy, output longint dz);
        longint unsigned turn_wide;
        logic [31:0]     turn;
        longint          vx, vy, vz, sx, sy, cs, sn, rad;
        turn_wide = (64'(i) << 32) / 64'(n);
        turn = turn_wide[31:0];
        vx = CORDIC_GAIN;
        vy = 0;
        vz = longint'(turn[29:0]);
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            sx = vy >>> k;
            sy = vx >>> k;
            if (vz >= 0)
            begin
                vx = vx - sx;
                vy = vy + sy;
                vz = vz - arc_turn[k];
            end
            else
            begin
                vx = vx + sx;
                vy = vy - sy;
                vz = vz + arc_turn[k];
            end
        end
        case (turn[31:30])
            2'd0:
            begin
                cs = vx;
                sn = vy;
            end
            2'd1:
            begin
                cs = -vy;
                sn = vx;
            end
            2'd2:
            begin
                cs = -vx;
                sn = -vy;
            end
            default:
            begin
                cs = vy;
                sn = -vx;
            end
        endcase
        rad = radius_now;
        dy = (rad * cs + ROUND_Q30) >>> 30;
        dz = (rad * sn + ROUND_Q30) >>> 30;
    endfunction

    function automatic void advance_sequence(input logic go, input logic arrived,
                                             output logic made, output logic acted,
                                             output cmd_word_t w);
        longint oy, oz;
        made = 1'b0;
        acted = 1'b1;
        w = '0;
        case (seq_phase)
            PH_IDLE:
                if (go)
                begin
                    drawn = '0;
                    seq_phase = PH_GO_CENTER;
                    w.kind = KIND_SPEED;
                    made = 1'b1;
                end
                else
                    acted = 1'b0;
            PH_GO_CENTER:
            begin
                seq_phase = PH_WAIT_CENTER;
                w.kind = KIND_POSE;
                w.x = ctr_x;
                w.y = ctr_y;
                w.z = ctr_z;
                made = 1'b1;
            end
            PH_WAIT_CENTER, PH_WAIT_STEP:
                if (arrived)
                    seq_phase = PH_DRAW;
                else
                    acted = 1'b0;
            PH_DRAW:
            begin
                made = 1'b1;
                if (drawn >= count_now)
                begin
                    seq_phase = PH_DONE;
                    w.kind = KIND_HOME;
                    w.fin = 1'b1;
                end
                else
                begin
                    circle_offsets(drawn, count_now, oy, oz);
                    w.kind = KIND_POSE;
                    w.x = ctr_x;
                    w.y = clamp_coord(longint'(ctr_y) + oy);
                    w.z = clamp_coord(longint'(ctr_z) + oz);
                    w.idx = drawn + 16'd1;
                    drawn = drawn + 16'd1;
                    seq_phase = PH_WAIT_STEP;
                end
            end
            default:
                acted = 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        mismatches++;
        if (mismatches <= 25)
            $display("mismatch %s at %0t (command %0d): got 0x%0h, expected 0x%0h",
                     what, $time, cmds_seen, seen, wanted);
    endtask

    always @(posedge clk)
    begin : port_watch
        cmd_word_t fresh, want;
        logic      made, acted;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                advance_sequence(start_req, ee_reached, made, acted, fresh);
                ticks_taken++;
                if (acted)
                    live_ticks++;
                if (made)
                    pending_cmds.push_back(fresh);
            end
            if (cmd_valid && !cmd_stall)
            begin
                cmds_seen++;
                if (pending_cmds.size() == 0)
                    report_mismatch("command with nothing pending", cmd_kind, 0);
                else
                begin
                    want = pending_cmds.pop_front();
                    if (cmd_kind !== want.kind)
                        report_mismatch("cmd_kind", cmd_kind, want.kind);
                    if (target_x !== want.x)
                        report_mismatch("target_x", target_x, want.x);
                    if (pose_y !== want.y)
                        report_mismatch("pose_y", pose_y, want.y);
                    if (pose_z !== want.z)
                        report_mismatch("pose_z", pose_z, want.z);
                    if (waypoint_index !== want.idx)
                        report_mismatch("waypoint_index", waypoint_index, want.idx);
                    if (finished !== want.fin)
                        report_mismatch("finished", finished, want.fin);
                    if (want.kind == KIND_POSE && want.idx != 0)
                        waypoints_seen++;
                    if (want.fin)
                        homes_seen++;
                end
            end
        end
    end

    // command receiver: long hold when asked, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            hold_off_left = hold_off_left - 1;
            cmd_stall <= 1'b1;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 160);
            end
            else
                stall_left = stall_left - 1;
            case (stall_mode)
                STALL_NONE:  cmd_stall <= 1'b0;
                STALL_LIGHT: cmd_stall <= ($urandom_range(0, 3) == 0);
                STALL_HALF:  cmd_stall <= 1'($urandom);
                default:     cmd_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (cmd_valid && !cmd_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no handshake for %0d cycles, giving up", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_BITS-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        cfg_writes++;
        case (idx)
            REG_CENTER_X: ctr_x = value;
            REG_CENTER_Y: ctr_y = value;
            REG_CENTER_Z: ctr_z = value;
            REG_RADIUS:   radius_now = value[RADIUS_BITS-1:0];
            REG_COUNT:    count_now = value[COUNT_BITS-1:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_tick(input logic go, input logic arrived);
        @(negedge clk);
        item_valid <= 1'b1;
        start_req <= go;
        ee_reached <= arrived;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge clk);
        item_valid <= 1'b0;
        start_req <= 1'($urandom);
        ee_reached <= 1'($urandom);
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // drain all pending commands, then let an in-flight tick finish
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic run_ticks(input int total, input int reached_pct, input bit steady);
        int left, burst;
        left = total;
        while (left > 0)
        begin
            burst = steady ? left : $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
                offer_tick(1'($urandom), $urandom_range(0, 99) < reached_pct);
            left -= burst;
            if (!steady)
                idle_gap($urandom_range(1, 12));
        end
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return {1'b0, {(COORD_BITS-1){1'b1}}};
            1:       return {1'b1, {(COORD_BITS-1){1'b0}}};
            2:       return '0;
            3:       return COORD_BITS'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_radius();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return {COORD_BITS{1'b1}};
            2:       return {1'b0, {(COORD_BITS-1){1'b1}}};
            3:       return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // new settings, keeping point_count clear of the counter
    task automatic shuffle_config();
        longint room;
        if ($urandom_range(0, 1))
            write_reg(REG_CENTER_X, pick_coord());
        if ($urandom_range(0, 1))
            write_reg(REG_CENTER_Y, pick_coord());
        if ($urandom_range(0, 1))
            write_reg(REG_CENTER_Z, pick_coord());
        if ($urandom_range(0, 1))
            write_reg(REG_RADIUS, pick_radius());
        room = longint'(drawn) + 170 + $urandom_range(0, 3 * int'(drawn) + 400);
        if (room > 65535 || $urandom_range(0, 15) == 0)
            room = 65535;
        write_reg(REG_COUNT, {16'($urandom), 16'(room)});
    endtask

    task automatic test_idle_ignore();
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b1);
        settle();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_CENTER_X, {1'b0, {(COORD_BITS-1){1'b1}}});
        write_reg(REG_CENTER_Y, 32'h7FFF0000);
        write_reg(REG_CENTER_Z, {1'b1, {(COORD_BITS-1){1'b0}}});
        write_reg(REG_RADIUS, {COORD_BITS{1'b1}});
        write_reg(REG_COUNT, 32'hABCD0004);
        for (int idx = int'(REG_COUNT) + 1; idx < (1 << CFG_IDX_BITS); idx++)
            write_reg(CFG_IDX_BITS'(idx), $urandom);
    endtask

    task automatic test_start_and_centre();
        offer_tick(1'b1, 1'b0);
        offer_tick(1'b1, 1'b1);
        offer_tick(1'b1, 1'b0);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b1);
        settle();
    endtask

    // four points land on the quadrant boundaries
    task automatic test_quadrant_steps();
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b1, 1'b0);
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b1, 1'b1);
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b0, 1'b0);
        settle();
        write_reg(REG_RADIUS, 32'h80000000);
        write_reg(REG_COUNT, 32'h5A5AFFFF);
        write_reg(REG_CENTER_X, {1'b1, {(COORD_BITS-1){1'b0}}});
        write_reg(REG_CENTER_Y, {1'b1, {(COORD_BITS-1){1'b0}}});
        write_reg(REG_CENTER_Z, {1'b0, {(COORD_BITS-1){1'b1}}});
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b0, 1'b0);
        settle();
        write_reg(REG_RADIUS, 32'h7FFFFFFF);
        offer_tick(1'b1, 1'b1);
        offer_tick(1'b0, 1'b1);
        settle();
    endtask

    task automatic test_random_tour(input int target);
        int len;
        while (ticks_taken < target)
        begin
            settle();
            shuffle_config();
            len = $urandom_range(40, 160);
            if (len > target - ticks_taken)
                len = target - ticks_taken;
            run_ticks(len, $urandom_range(55, 95), $urandom_range(0, 2) == 0);
        end
    endtask

    task automatic test_backpressure();
        settle();
        shuffle_config();
        hold_off_left = HOLD_CYCLES;
        run_ticks(60, 90, 1'b1);
        settle();
    endtask

    task automatic test_finish_and_lockout();
        logic [COUNT_BITS-1:0] last;
        settle();
        case ($urandom_range(0, 2))
            0:       last = '0;
            1:       last = drawn;
            default: last = drawn >> 1;
        endcase
        write_reg(REG_COUNT, {16'($urandom), last});
        offer_tick(1'b1, 1'b1);
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b1, 1'b1);
        offer_tick(1'b1, 1'b0);
        offer_tick(1'b0, 1'b1);
        settle();
        offer_tick(1'b1, 1'b0);
        settle();
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_ignore();
        test_config_extremes();
        test_start_and_centre();
        test_quadrant_steps();
        test_random_tour(700);
        test_backpressure();
        test_random_tour(1440);
        test_finish_and_lockout();
        if (pending_cmds.size() != 0)
            report_mismatch("commands never issued", pending_cmds.size(), 0);
        $display("Run covered %0d ticks (%0d acting on the sequence) and %0d commands.",
                 ticks_taken, live_ticks, cmds_seen);
        $display("That took %0d waypoints, %0d home command(s) and %0d register writes.",
                 waypoints_seen, homes_seen, cfg_writes);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
